// ----- rtl/equity_curve_performance_stats_core_assert.svh -----
// assertion macros for the equity curve statistics core
// no dependencies; included by the top level only
`ifndef EQUITY_CURVE_PERFORMANCE_STATS_CORE_ASSERT_SVH
`define EQUITY_CURVE_PERFORMANCE_STATS_CORE_ASSERT_SVH
`ifndef SYNTH
`define ECPS_ASSERT_IMP(label, clk, rstn, ante, cons) \
label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
	else $error("ecps assertion failed");
`define ECPS_ASSERT_NXT(label, clk, rstn, ante, cons) \
label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
	else $error("ecps assertion failed");
`else
`define ECPS_ASSERT_IMP(label, clk, rstn, ante, cons)
`define ECPS_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif
`endif

// ----- rtl/ecps_pkg.sv -----
// shared types and constants of the equity curve statistics core
// no dependencies
package ecps_pkg;

	localparam logic [31:0] CAP_POS    = 32'h7FFF_FFFF;
	localparam logic [31:0] CAP_NEG    = 32'h8000_0000;
	localparam logic [33:0] VAR_CAP    = 34'h3_FFFF_FFFF;
	localparam logic [24:0] ANNUAL_Q16 = 25'd20545301;

	localparam logic [1:0] CFG_STARTING_CASH   = 2'd0;
	localparam logic [1:0] CFG_REALIZED_PROFIT = 2'd1;
	localparam logic [1:0] CFG_TRADES_DONE     = 2'd2;

	typedef struct packed {
		logic        start;
		logic        long_mode;
		logic [79:0] dividend;
		logic [47:0] divisor;
		logic [31:0] cap;
	} div_req_t;

	typedef struct packed {
		logic        busy;
		logic        done;
		logic [47:0] quot;
	} div_rsp_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_RET_PREP,
		S_RET_DIV,
		S_RET_WAIT,
		S_PEAK,
		S_DD_DIV,
		S_DD_WAIT,
		S_TOT_PREP,
		S_TOT_DIV,
		S_TOT_WAIT,
		S_MEAN_DIV,
		S_MEAN_WAIT,
		S_VAR_ADDR,
		S_VAR_DIFF,
		S_VAR_MUL,
		S_VAR_ACC,
		S_VDIV,
		S_VDIV_WAIT,
		S_SQRT,
		S_SH_MUL,
		S_SH_DIV,
		S_SH_WAIT,
		S_AVG_DIV,
		S_AVG_WAIT,
		S_EMIT
	} seq_state_t;

endpackage

// ----- rtl/ecps_ram.sv -----
// generic single write port, single read port ram with registered read
// no dependencies
module ecps_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

// ----- rtl/ecps_divider.sv -----
// shared restoring divider, one quotient bit per cycle
// depends on ecps_pkg
module ecps_divider (
	input  logic              clk,
	input  logic              arst_n,
	input  ecps_pkg::div_req_t req,
	output ecps_pkg::div_rsp_t rsp
);
	import ecps_pkg::*;

	logic        busy_q, done_q;
	logic [5:0]  cnt_q;
	logic        long_q, sat_q;
	logic [47:0] rem_q, quot_q, div_q;
	logic [79:0] x_q;
	logic [31:0] cap_q;
	logic [48:0] trial;
	logic        ge;
	logic [47:0] rem_nx;
	logic [47:0] quot_out;

	assign trial  = {rem_q, x_q[79]};
	assign ge     = trial >= {1'b0, div_q};
	assign rem_nx = ge ? 48'(trial - {1'b0, div_q}) : trial[47:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.long_mode ? 6'd48 : 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			long_q <= req.long_mode;
			cap_q  <= req.cap;
			div_q  <= req.divisor;
			quot_q <= '0;
			// quotient would not fit 32 bits: saturate
			sat_q  <= !req.long_mode && (req.dividend >= {req.divisor, 32'd0});
			if (req.long_mode) begin
				rem_q <= 48'(req.dividend[79:48]);
				x_q   <= req.dividend << 32;
			end else begin
				rem_q <= req.dividend[79:32];
				x_q   <= req.dividend << 48;
			end
		end else if (busy_q) begin
			rem_q  <= rem_nx;
			x_q    <= x_q << 1;
			quot_q <= {quot_q[46:0], ge};
		end
	end

	always_comb begin
		if (long_q) begin
			quot_out = quot_q;
		end else if (sat_q || quot_q > 48'(cap_q)) begin
			quot_out = 48'(cap_q);
		end else begin
			quot_out = quot_q;
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quot = quot_out;
endmodule

// ----- rtl/equity_curve_performance_stats_core.sv -----
// top level of the equity curve statistics core: sequencer, curve state, result register
// depends on ecps_pkg, ecps_divider, ecps_ram and the assertion header
`include "equity_curve_performance_stats_core_assert.svh"

// Takes an equity curve one sample per transfer, the last one marked by final_sample,
// and on that last sample delivers one result: total return percent against starting
// cash, annualised Sharpe ratio, max drawdown percent, average trade profit and the
// trade count. Every division runs on one shared restoring divider that retires one
// quotient bit per cycle (32-bit for saturating fractions, 48-bit for plain quotients).
// A sample runs at most a step return and a drawdown divide; a final sample adds the
// total return and, given two or more returns, the mean, a walk through the stored
// returns, the variance divide, a 32-step square root, the Sharpe divide and the average
// trade divide. The block takes no new sample while one is in flight; a finished result
// sits in the output register and the next sample is accepted meanwhile. The return
// memory needs no clearing after reset. Configuration is written through
// cfg_we/cfg_index/cfg_data; the user must do so only while idle; it is not checked.
module equity_curve_performance_stats_core #(
	parameter int MAX_SAMPLES = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [47:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [47:0] equity_value,
	input  logic               final_sample,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] return_pct,
	output logic signed [31:0] sharpe_value,
	output logic [30:0]        drawdown_pct,
	output logic signed [47:0] avg_trade_profit,
	output logic [31:0]        trade_total,
	output logic               divide_fault
);
	import ecps_pkg::*;

	localparam int AW  = $clog2(MAX_SAMPLES);
	localparam int CW  = $clog2(MAX_SAMPLES + 1);
	localparam int SQW = 34 + CW;

	seq_state_t state_q, state_nx;

	// configuration
	logic signed [47:0] sc_q, rp_q;
	logic [31:0]        trades_q;

	// curve state
	logic [CW-1:0]      count_q;
	logic signed [47:0] prev_q, peak_q, sum_q;
	logic               seen_q;
	logic [30:0]        worst_q;

	// working registers
	logic signed [47:0] e_q;
	logic               fin_q;
	logic [48:0]        mag_q;
	logic               neg_q;
	logic signed [31:0] mean_q;
	logic [CW-1:0]      i_q;
	logic [31:0]        d_q;
	logic [63:0]        prod_q;
	logic [SQW-1:0]     sq_q;
	logic [63:0]        sv_q;
	logic [31:0]        root_q;
	logic [33:0]        rem_q;
	logic [4:0]         k_q;
	logic [56:0]        prod2_q;
	logic signed [31:0] tot_q, sharpe_q;
	logic signed [47:0] avg_q;
	logic               fault_q;

	// output register
	logic               out_valid_q;
	logic signed [31:0] tot_out_q, sharpe_out_q;
	logic [30:0]        dd_out_q;
	logic signed [47:0] avg_out_q;
	logic [31:0]        trades_out_q;
	logic               fault_out_q;

	div_req_t div_req;
	div_rsp_t div_rsp;

	logic          ram_we;
	logic [31:0]   ram_rdata;
	logic          accept, out_load, out_take;

	// combinational helpers
	logic signed [48:0] ep_diff, es_diff, pe_diff;
	logic signed [47:0] pk_nx;
	logic [47:0]        prev_mag, sc_mag, rp_mag, sum_mag;
	logic [31:0]        mean_mag;
	logic [55:0]        mag100;
	logic [31:0]        q32s;
	logic [47:0]        q48s;
	logic signed [32:0] rd_diff;
	logic [35:0]        rem_sh, sq_trial;
	logic               sq_ge;
	logic [33:0]        var_val;
	logic [CW-1:0]      i_inc;

	assign accept   = in_valid && !in_stall;
	assign out_take = out_valid_q && !out_stall;
	assign out_load = (state_q == S_EMIT) && (!out_valid_q || !out_stall);

	assign ep_diff  = 49'(e_q) - 49'(prev_q);
	assign es_diff  = 49'(e_q) - 49'(sc_q);
	assign pk_nx    = (!seen_q || e_q > peak_q) ? e_q : peak_q;
	assign pe_diff  = 49'(pk_nx) - 49'(e_q);
	assign prev_mag = prev_q[47] ? 48'(-prev_q) : 48'(prev_q);
	assign sc_mag   = sc_q[47] ? 48'(-sc_q) : 48'(sc_q);
	assign rp_mag   = rp_q[47] ? 48'(-rp_q) : 48'(rp_q);
	assign sum_mag  = sum_q[47] ? 48'(-sum_q) : 48'(sum_q);
	assign mean_mag = mean_q[31] ? 32'(-mean_q) : 32'(mean_q);
	// times 100 as shift-adds
	assign mag100   = 56'({mag_q, 6'b0}) + 56'({mag_q, 5'b0}) + 56'({mag_q, 2'b0});

	// sign applied to the magnitude from the divider
	assign q32s = neg_q ? (32'd0 - div_rsp.quot[31:0]) : div_rsp.quot[31:0];
	assign q48s = neg_q ? (48'd0 - div_rsp.quot) : div_rsp.quot;

	assign rd_diff = 33'($signed(ram_rdata)) - 33'(mean_q);

	// one root bit per step
	assign rem_sh   = {rem_q, sv_q[63:62]};
	assign sq_trial = 36'({root_q, 2'b01});
	assign sq_ge    = rem_sh >= sq_trial;

	assign var_val = (div_rsp.quot > 48'(VAR_CAP)) ? VAR_CAP : div_rsp.quot[33:0];
	assign i_inc   = i_q + CW'(1);

	ecps_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	ecps_ram #(
		.WIDTH (32),
		.DEPTH (MAX_SAMPLES)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[AW-1:0]),
		.wdata (q32s),
		.raddr (i_q[AW-1:0]),
		.rdata (ram_rdata)
	);

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_nx = S_RET_PREP;
				end
			end
			S_RET_PREP: begin
				state_nx = (seen_q && prev_q != 48'sd0) ? S_RET_DIV : S_PEAK;
			end
			S_RET_DIV: state_nx = S_RET_WAIT;
			S_RET_WAIT: begin
				if (div_rsp.done) begin
					state_nx = S_PEAK;
				end
			end
			S_PEAK: begin
				if (pk_nx > 48'sd0) begin
					state_nx = S_DD_DIV;
				end else begin
					state_nx = fin_q ? S_TOT_PREP : S_IDLE;
				end
			end
			S_DD_DIV: state_nx = S_DD_WAIT;
			S_DD_WAIT: begin
				if (div_rsp.done) begin
					state_nx = fin_q ? S_TOT_PREP : S_IDLE;
				end
			end
			S_TOT_PREP: begin
				if (sc_q != 48'sd0) begin
					state_nx = S_TOT_DIV;
				end else begin
					state_nx = (count_q < CW'(2)) ? S_AVG_DIV : S_MEAN_DIV;
				end
			end
			S_TOT_DIV: state_nx = S_TOT_WAIT;
			S_TOT_WAIT: begin
				if (div_rsp.done) begin
					state_nx = (count_q < CW'(2)) ? S_AVG_DIV : S_MEAN_DIV;
				end
			end
			S_MEAN_DIV: state_nx = S_MEAN_WAIT;
			S_MEAN_WAIT: begin
				if (div_rsp.done) begin
					state_nx = S_VAR_ADDR;
				end
			end
			S_VAR_ADDR: state_nx = S_VAR_DIFF;
			S_VAR_DIFF: state_nx = S_VAR_MUL;
			S_VAR_MUL:  state_nx = S_VAR_ACC;
			S_VAR_ACC:  state_nx = (i_inc == count_q) ? S_VDIV : S_VAR_ADDR;
			S_VDIV:     state_nx = S_VDIV_WAIT;
			S_VDIV_WAIT: begin
				if (div_rsp.done) begin
					state_nx = S_SQRT;
				end
			end
			S_SQRT: begin
				if (k_q == 5'd31) begin
					state_nx = S_SH_MUL;
				end
			end
			S_SH_MUL: state_nx = (root_q == 32'd0) ? S_AVG_DIV : S_SH_DIV;
			S_SH_DIV: state_nx = S_SH_WAIT;
			S_SH_WAIT: begin
				if (div_rsp.done) begin
					state_nx = S_AVG_DIV;
				end
			end
			S_AVG_DIV: state_nx = (trades_q == 32'd0) ? S_EMIT : S_AVG_WAIT;
			S_AVG_WAIT: begin
				if (div_rsp.done) begin
					state_nx = S_EMIT;
				end
			end
			S_EMIT: begin
				if (out_load) begin
					state_nx = S_IDLE;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

	// divider requests, memory write, handshake
	always_comb begin
		div_req           = '0;
		div_req.cap       = neg_q ? CAP_NEG : CAP_POS;
		ram_we            = 1'b0;
		in_stall          = (state_q != S_IDLE);
		unique case (state_q)
			S_RET_DIV: begin
				div_req.start    = 1'b1;
				div_req.dividend = {1'b0, mag_q, 30'd0};
				div_req.divisor  = prev_mag;
			end
			S_RET_WAIT: begin
				ram_we = div_rsp.done && (count_q < CW'(MAX_SAMPLES));
			end
			S_DD_DIV: begin
				div_req.start    = 1'b1;
				div_req.dividend = {8'd0, mag100, 16'd0};
				div_req.divisor  = 48'(peak_q);
			end
			S_TOT_DIV: begin
				div_req.start    = 1'b1;
				div_req.dividend = {8'd0, mag100, 16'd0};
				div_req.divisor  = sc_mag;
			end
			S_MEAN_DIV: begin
				div_req.start     = 1'b1;
				div_req.long_mode = 1'b1;
				div_req.dividend  = 80'(sum_mag);
				div_req.divisor   = 48'(count_q);
			end
			S_VDIV: begin
				div_req.start     = 1'b1;
				div_req.long_mode = 1'b1;
				div_req.dividend  = 80'(sq_q);
				div_req.divisor   = 48'(count_q - CW'(1));
			end
			S_SH_DIV: begin
				div_req.start    = 1'b1;
				div_req.dividend = 80'(prod2_q);
				div_req.divisor  = 48'(root_q);
			end
			S_AVG_DIV: begin
				div_req.start     = (trades_q != 32'd0);
				div_req.long_mode = 1'b1;
				div_req.dividend  = 80'(rp_mag);
				div_req.divisor   = 48'(trades_q);
			end
			default: begin
			end
		endcase
	end

	// control, configuration and curve state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			sc_q        <= '0;
			rp_q        <= '0;
			trades_q    <= '0;
			count_q     <= '0;
			prev_q      <= '0;
			seen_q      <= 1'b0;
			peak_q      <= '0;
			worst_q     <= '0;
			sum_q       <= '0;
		end else begin
			state_q <= state_nx;
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_STARTING_CASH:   sc_q     <= $signed(cfg_data);
					CFG_REALIZED_PROFIT: rp_q     <= $signed(cfg_data);
					CFG_TRADES_DONE:     trades_q <= cfg_data[31:0];
					default: begin
					end
				endcase
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end
			// store the step return while the store has room
			if (ram_we) begin
				count_q <= count_q + CW'(1);
				sum_q   <= sum_q + 48'($signed(q32s));
			end
			if (state_q == S_PEAK) begin
				peak_q <= pk_nx;
				prev_q <= e_q;
				seen_q <= 1'b1;
			end
			if (state_q == S_DD_WAIT && div_rsp.done && div_rsp.quot[30:0] > worst_q) begin
				worst_q <= div_rsp.quot[30:0];
			end
			// new curve once the result is loaded into the output register
			if (out_load) begin
				count_q <= '0;
				prev_q  <= '0;
				seen_q  <= 1'b0;
				peak_q  <= '0;
				worst_q <= '0;
				sum_q   <= '0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			e_q   <= equity_value;
			fin_q <= final_sample;
		end
		unique case (state_q)
			S_RET_PREP: begin
				mag_q <= ep_diff[48] ? 49'(-ep_diff) : 49'(ep_diff);
				neg_q <= ep_diff[48] ^ prev_q[47];
			end
			S_PEAK: begin
				mag_q <= 49'(pe_diff);
				neg_q <= 1'b0;
			end
			S_TOT_PREP: begin
				mag_q    <= es_diff[48] ? 49'(-es_diff) : 49'(es_diff);
				neg_q    <= es_diff[48] ^ sc_q[47];
				fault_q  <= (sc_q == 48'sd0);
				tot_q    <= '0;
				sharpe_q <= '0;
				avg_q    <= '0;
			end
			S_TOT_WAIT: begin
				if (div_rsp.done) begin
					tot_q <= $signed(q32s);
				end
			end
			S_MEAN_DIV: begin
				neg_q <= sum_q[47];
			end
			S_MEAN_WAIT: begin
				mean_q <= $signed(q32s);
				i_q    <= '0;
				sq_q   <= '0;
			end
			S_VAR_DIFF: begin
				d_q <= rd_diff[32] ? 32'(-rd_diff) : 32'(rd_diff);
			end
			S_VAR_MUL: begin
				prod_q <= 64'(d_q) * 64'(d_q);
			end
			S_VAR_ACC: begin
				sq_q <= sq_q + SQW'(prod_q[63:30]);
				i_q  <= i_inc;
			end
			S_VDIV_WAIT: begin
				sv_q   <= {var_val, 30'd0};
				root_q <= '0;
				rem_q  <= '0;
				k_q    <= '0;
			end
			S_SQRT: begin
				sv_q <= sv_q << 2;
				k_q  <= k_q + 5'd1;
				if (sq_ge) begin
					rem_q  <= 34'(rem_sh - sq_trial);
					root_q <= {root_q[30:0], 1'b1};
				end else begin
					rem_q  <= rem_sh[33:0];
					root_q <= {root_q[30:0], 1'b0};
				end
			end
			S_SH_MUL: begin
				prod2_q <= 57'(mean_mag) * 57'(ANNUAL_Q16);
				neg_q   <= mean_q[31];
			end
			S_SH_WAIT: begin
				if (div_rsp.done) begin
					sharpe_q <= $signed(q32s);
				end
			end
			S_AVG_DIV: begin
				neg_q <= rp_q[47];
			end
			S_AVG_WAIT: begin
				if (div_rsp.done) begin
					avg_q <= $signed(q48s);
				end
			end
			default: begin
			end
		endcase
		if (out_load) begin
			tot_out_q    <= tot_q;
			sharpe_out_q <= sharpe_q;
			dd_out_q     <= worst_q;
			avg_out_q    <= avg_q;
			trades_out_q <= trades_q;
			fault_out_q  <= fault_q;
		end
	end

	assign out_valid        = out_valid_q;
	assign return_pct       = tot_out_q;
	assign sharpe_value     = sharpe_out_q;
	assign drawdown_pct     = dd_out_q;
	assign avg_trade_profit = avg_out_q;
	assign trade_total      = trades_out_q;
	assign divide_fault     = fault_out_q;

	// checks
	`ECPS_ASSERT_IMP(a_count_bound, clk, arst_n, 1'b1, count_q <= CW'(MAX_SAMPLES))
	`ECPS_ASSERT_IMP(a_div_start_idle, clk, arst_n, div_req.start, !div_rsp.busy)
	`ECPS_ASSERT_NXT(a_emit_valid, clk, arst_n, out_load, out_valid_q)
	`ECPS_ASSERT_IMP(a_walk_range, clk, arst_n, state_q == S_VAR_ACC, i_q < count_q)
endmodule

// ----- dv/equity_curve_performance_stats_core_test.sv -----
// self-checking testbench of the equity curve statistics core
// depends on ecps_pkg and the core; a scoreboard class predicts each result
`timescale 1ns / 100ps

module equity_curve_performance_stats_core_test;
	import ecps_pkg::*;

	localparam int STORE_DEPTH = 1024;
	localparam longint unsigned ANNUAL = 64'd20545301;
	localparam int IDLE_LIMIT = 20000;

	typedef struct {
		logic [31:0] tot;
		logic [31:0] shp;
		logic [30:0] dd;
		logic [47:0] avg;
		logic [31:0] trades;
		logic        fault;
	} stats_t;

	// predicts the statistics of each curve and holds them until delivered
	class curve_stats_board;
		longint cash;
		longint profit;
		longint unsigned trades;
		int rets [STORE_DEPTH];
		int unsigned n_rets;
		longint prev_e;
		bit started;
		longint peak;
		longint unsigned worst;
		longint ret_sum;
		stats_t pending_q [$];
		int errors;
		int results;

		function new();
			cash = 0;
			profit = 0;
			trades = 0;
			errors = 0;
			results = 0;
			restart();
		endfunction

		function void restart();
			n_rets = 0;
			prev_e = 0;
			started = 0;
			peak = 0;
			worst = 0;
			ret_sum = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [47:0] val);
			if (idx == CFG_STARTING_CASH)
				cash = longint'($signed(val));
			else if (idx == CFG_REALIZED_PROFIT)
				profit = longint'($signed(val));
			else if (idx == CFG_TRADES_DONE)
				trades = {32'd0, val[31:0]};
		endfunction

		static function longint unsigned mag(longint v);
			return v < 0 ? -v : v;
		endfunction

		// floor(a * 2^s / b) capped
		static function longint unsigned frac_div(longint unsigned a, longint unsigned b,
				int s, longint unsigned cap);
			longint unsigned q, r;
			q = a / b;
			r = a % b;
			if (q > (cap >> s))
				return cap;
			for (int i = 0; i < s; i++) begin
				r = r << 1;
				q = q << 1;
				if (r >= b) begin
					r = r - b;
					q = q | 1;
				end
			end
			return q > cap ? cap : q;
		endfunction

		static function longint sat_div(longint num, longint den, int s);
			bit neg;
			longint unsigned q;
			neg = (num < 0) != (den < 0);
			q = frac_div(mag(num), mag(den), s, neg ? {32'd0, CAP_NEG} : {32'd0, CAP_POS});
			return neg ? -longint'(q) : longint'(q);
		endfunction

		static function longint unsigned int_sqrt(longint unsigned v);
			longint unsigned res, bitv;
			res = 0;
			bitv = 64'd1 << 62;
			while (bitv > v)
				bitv = bitv >> 2;
			while (bitv != 0) begin
				if (v >= res + bitv) begin
					v = v - (res + bitv);
					res = (res >> 1) + bitv;
				end else begin
					res = res >> 1;
				end
				bitv = bitv >> 2;
			end
			return res;
		endfunction

		function longint sharpe();
			longint mean;
			longint unsigned sq, var_q, sd, d;
			if (n_rets < 2)
				return 0;
			mean = ret_sum / longint'(n_rets);
			sq = 0;
			for (int i = 0; i < n_rets; i++) begin
				d = mag(longint'(rets[i]) - mean);
				sq = sq + ((d * d) >> 30);
			end
			var_q = sq / (n_rets - 1);
			if (var_q > {30'd0, VAR_CAP})
				var_q = {30'd0, VAR_CAP};
			sd = int_sqrt(var_q << 30);
			if (sd == 0)
				return 0;
			return sat_div(mean * longint'(ANNUAL), longint'(sd), 0);
		endfunction

		function void note_sample(logic [47:0] raw, logic fin);
			longint e, r;
			longint unsigned ddv;
			stats_t s;
			e = longint'($signed(raw));
			if (started && prev_e != 0) begin
				r = sat_div(e - prev_e, prev_e, 30);
				if (n_rets < STORE_DEPTH) begin
					rets[n_rets] = int'(r);
					n_rets++;
					ret_sum += r;
				end
			end
			if (!started || e > peak)
				peak = e;
			if (peak > 0) begin
				ddv = frac_div(longint'(peak - e) * 100, peak, 16, {32'd0, CAP_POS});
				if (ddv > worst)
					worst = ddv;
			end
			prev_e = e;
			started = 1;
			if (!fin)
				return;
			s.fault = (cash == 0);
			if (cash == 0)
				s.tot = '0;
			else
				s.tot = 32'(sat_div((e - cash) * 100, cash, 16));
			s.shp = 32'(sharpe());
			s.dd = worst[30:0];
			if (trades != 0)
				s.avg = 48'(profit / longint'(trades));
			else
				s.avg = '0;
			s.trades = trades[31:0];
			pending_q.insert(pending_q.size(), s);
			restart();
		endfunction

		function void check_stats(stats_t got);
			stats_t w;
			if (pending_q.size() == 0) begin
				$display("%0t: unexpected result tot=%h", $time, got.tot);
				errors++;
				return;
			end
			w = pending_q.pop_front();
			results++;
			if (got.tot !== w.tot) begin
				$display("%0t: return_pct exp %h got %h", $time, w.tot, got.tot);
				errors++;
			end
			if (got.shp !== w.shp) begin
				$display("%0t: sharpe_value exp %h got %h", $time, w.shp, got.shp);
				errors++;
			end
			if (got.dd !== w.dd) begin
				$display("%0t: drawdown_pct exp %h got %h", $time, w.dd, got.dd);
				errors++;
			end
			if (got.avg !== w.avg) begin
				$display("%0t: avg_trade_profit exp %h got %h", $time, w.avg, got.avg);
				errors++;
			end
			if (got.trades !== w.trades) begin
				$display("%0t: trade_total exp %h got %h", $time, w.trades, got.trades);
				errors++;
			end
			if (got.fault !== w.fault) begin
				$display("%0t: divide_fault exp %b got %b", $time, w.fault, got.fault);
				errors++;
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [1:0]         cfg_index;
	logic [47:0]        cfg_data;
	logic               in_valid;
	logic               in_stall;
	logic signed [47:0] equity_value;
	logic               final_sample;
	logic               out_valid;
	logic               out_stall;
	logic signed [31:0] return_pct;
	logic signed [31:0] sharpe_value;
	logic [30:0]        drawdown_pct;
	logic signed [47:0] avg_trade_profit;
	logic [31:0]        trade_total;
	logic               divide_fault;

	equity_curve_performance_stats_core dut (.*);

	curve_stats_board board = new();
	int samples_sent = 0;
	int curves_sent = 0;
	int idle_cycles = 0;
	bit send_burst = 0;
	bit recv_burst = 0;
	bit long_hold_req = 0;

	initial clk = 0;
	always #2 clk = ~clk;

	// result monitor: a transfer happens on a rising edge with valid and no stall
	always @(posedge clk) begin
		stats_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.tot = return_pct;
			got.shp = sharpe_value;
			got.dd = drawdown_pct;
			got.avg = avg_trade_profit;
			got.trades = trade_total;
			got.fault = divide_fault;
			board.check_stats(got);
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: watchdog, no transfer for %0d cycles", $time, idle_cycles);
			$display("equity_curve_performance_stats_core: mismatch");
			$finish;
		end
	end

	// receiver stall pattern, one draw per result, with an occasional long hold-off
	initial begin
		int hold;
		out_stall = 1;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_hold_req) begin
				hold = 3000;
				long_hold_req = 0;
			end else begin
				hold = recv_burst ? 0 : $urandom_range(0, 7);
			end
			if (hold > 0) begin
				out_stall = 1;
				repeat (hold) @(negedge clk);
			end
			out_stall = 0;
			do @(posedge clk); while (!out_valid);
			if ($urandom_range(0, 15) == 0)
				recv_burst = !recv_burst;
		end
	end

	task automatic write_reg(logic [1:0] idx, logic [47:0] val);
		@(negedge clk);
		cfg_we = 1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 0;
		board.set_reg(idx, val);
	endtask

	// registers change only once every result is out and the core has gone idle
	task automatic set_config(logic [47:0] cash, logic [47:0] pnl, logic [31:0] ntrades);
		while (board.pending_q.size() != 0)
			@(negedge clk);
		repeat (120) @(negedge clk);
		write_reg(CFG_STARTING_CASH, cash);
		write_reg(CFG_REALIZED_PROFIT, pnl);
		write_reg(CFG_TRADES_DONE, {16'd0, ntrades});
	endtask

	task automatic send_sample(logic [47:0] e, logic fin);
		int gap;
		gap = send_burst ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			in_valid = 0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1;
		equity_value = e;
		final_sample = fin;
		do @(posedge clk); while (in_stall);
		board.note_sample(e, fin);
		samples_sent++;
		@(negedge clk);
		in_valid = 0;
	endtask

	function automatic logic [47:0] rand48();
		return 48'({$urandom(), $urandom()});
	endfunction

	// one equity sample in the given style
	function automatic logic [47:0] pick_equity(int style, longint base);
		longint span;
		case (style)
			0: return rand48();
			1: begin
				span = base / 8 + 1;
				return 48'(base + longint'($urandom_range(0, 2 * 1000)) * span / 1000 - span);
			end
			2: return 48'(longint'($urandom_range(0, 10)) - 5);
			default: begin
				case ($urandom_range(0, 4))
					0: return 48'h7FFF_FFFF_FFFF;
					1: return 48'h8000_0000_0000;
					2: return 48'd0;
					3: return 48'd1;
					default: return 48'hFFFF_FFFF_FFFF;
				endcase
			end
		endcase
	endfunction

	task automatic send_curve(int len, int style);
		longint base;
		int s;
		base = longint'({$urandom_range(1, 32'hFFFF), $urandom()}) >>> $urandom_range(0, 40);
		if (base == 0)
			base = 1;
		if ($urandom_range(0, 7) == 0)
			send_burst = !send_burst;
		for (int i = 0; i < len; i++) begin
			s = style;
			// a few stray samples of another kind inside a well-formed curve
			if (style == 1 && $urandom_range(0, 19) == 0)
				s = $urandom_range(0, 3);
			send_sample(pick_equity(s, base), i == len - 1);
		end
		curves_sent++;
	endtask

	initial begin
		int len, style, r;
		arst_n = 0;
		cfg_we = 0;
		cfg_index = CFG_STARTING_CASH;
		cfg_data = '0;
		in_valid = 0;
		equity_value = '0;
		final_sample = 0;
		repeat (3) @(negedge clk);
		arst_n = 1;

		// zero starting cash from reset: fault, single sample gives no returns
		send_sample(48'd1000, 1);
		set_config(48'd1000, 48'h7FFF_FFFF_FFFF, 32'd1);
		// flat curve, zero deviation
		send_sample(48'd500, 0);
		send_sample(48'd500, 0);
		send_sample(48'd500, 1);
		// zero previous equity skips a return, non-positive peak
		send_sample(48'd0, 0);
		send_sample(48'hFFFF_FFFF_FFF0, 0);
		send_sample(48'd0, 0);
		send_sample(48'd3, 1);
		set_config(48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000, 32'hFFFF_FFFF);
		// saturating returns and drawdown
		send_sample(48'd1, 0);
		send_sample(48'h7FFF_FFFF_FFFF, 0);
		send_sample(48'h8000_0000_0000, 0);
		send_sample(48'd1, 0);
		send_sample(48'h8000_0000_0000, 1);
		set_config(48'h8000_0000_0000, 48'd12345, 32'd0);
		send_sample(48'h7FFF_FFFF_FFFF, 0);
		send_sample(48'd2, 1);
		set_config(48'd1, 48'hFFFF_FFFF_FF00, 32'd7);
		send_sample(48'h7FFF_FFFF_FFFF, 1);
		// store overflow: more returns than the memory holds
		send_curve(STORE_DEPTH + 6, 1);

		// random phases with their own settings
		while (samples_sent < 1600) begin
			r = $urandom_range(0, 5);
			case (r)
				0: set_config(48'd0, rand48(), $urandom());
				1: set_config(48'h7FFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF, 32'hFFFF_FFFF);
				2: set_config(48'h8000_0000_0000, 48'h8000_0000_0000, 32'd1);
				default: set_config(rand48() >>> $urandom_range(0, 40), rand48(),
					$urandom() >> $urandom_range(0, 31));
			endcase
			// output held off while the sender keeps going
			if (curves_sent % 5 == 2)
				long_hold_req = 1;
			repeat ($urandom_range(4, 12)) begin
				len = $urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : $urandom_range(2, 24);
				r = $urandom_range(0, 9);
				style = r < 7 ? 1 : r - 7;
				send_curve(len, style);
			end
		end
		in_valid = 0;

		while (board.pending_q.size() != 0)
			@(negedge clk);
		repeat (400) @(negedge clk);
		$display("run covered %0d samples in %0d curves, %0d results checked",
			samples_sent, curves_sent, board.results);
		if (board.errors == 0 && board.pending_q.size() == 0)
			$display("equity_curve_performance_stats_core: match");
		else
			$display("equity_curve_performance_stats_core: mismatch");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/ecps_pkg.sv
rtl/ecps_ram.sv
rtl/ecps_divider.sv
rtl/equity_curve_performance_stats_core.sv
dv/equity_curve_performance_stats_core_test.sv
